[rtl/core/sm83ls_pkg.sv]
// Shared types, codes and register-file helpers for the SM83 load/store unit.
// No dependencies; imported by sm83ls_exec and sm83_load_store_unit.
package sm83ls_pkg;

	// Command codes of an input transaction
	localparam logic CMD_EXEC   = 1'b0;
	localparam logic CMD_RETURN = 1'b1;

	// Bus access kinds of a result transaction
	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_READ  = 2'd2;

	// 8-bit register codes as encoded in the opcode
	localparam logic [2:0] REG_B   = 3'd0;
	localparam logic [2:0] REG_C   = 3'd1;
	localparam logic [2:0] REG_D   = 3'd2;
	localparam logic [2:0] REG_E   = 3'd3;
	localparam logic [2:0] REG_H   = 3'd4;
	localparam logic [2:0] REG_L   = 3'd5;
	localparam logic [2:0] REG_MEM = 3'd6;
	localparam logic [2:0] REG_A   = 3'd7;

	// Opcodes and opcode classes
	localparam logic [7:0] OP_HALT      = 8'h76;
	localparam logic [7:0] OP_MOVE_LO   = 8'h40;
	localparam logic [7:0] OP_MOVE_HI   = 8'h7F;
	localparam logic [7:0] OP_D8_MASK   = 8'hC7;
	localparam logic [7:0] OP_D8_MATCH  = 8'h06;
	localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
	localparam logic [7:0] OP_LD_DE_D16 = 8'h11;
	localparam logic [7:0] OP_LD_HL_D16 = 8'h21;
	localparam logic [7:0] OP_LD_SP_D16 = 8'h31;
	localparam logic [7:0] OP_ST_BC_A   = 8'h02;
	localparam logic [7:0] OP_ST_DE_A   = 8'h12;
	localparam logic [7:0] OP_ST_HLI_A  = 8'h22;
	localparam logic [7:0] OP_ST_HLD_A  = 8'h32;
	localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
	localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
	localparam logic [7:0] OP_LD_A_HLI  = 8'h2A;
	localparam logic [7:0] OP_LD_A_HLD  = 8'h3A;
	localparam logic [7:0] OP_LDH_A8_A  = 8'hE0;
	localparam logic [7:0] OP_LDH_C_A   = 8'hE2;
	localparam logic [7:0] OP_ST_A16_A  = 8'hEA;
	localparam logic [7:0] OP_LDH_A_A8  = 8'hF0;
	localparam logic [7:0] OP_LDH_A_C   = 8'hF2;
	localparam logic [7:0] OP_LD_A_A16  = 8'hFA;
	localparam logic [7:0] OP_ST_A16_SP = 8'h08;
	localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
	localparam logic [7:0] OP_LD_HL_SPR = 8'hF8;

	localparam logic [7:0] HIGH_PAGE = 8'hFF;

	// Architectural state
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [15:0] sp;
		logic [3:0]  flags;
		logic        rd_pend;
		logic [2:0]  rd_tgt;
		logic [2:0]  pend_cyc;
	} sm83ls_state_t;

	// Bus part of one result
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [2:0]  cyc;
		logic        last;
		logic        unsup;
	} sm83ls_result_t;

	// Handshake control from execute to the top level
	typedef struct packed {
		logic emit;
		logic more;
	} sm83ls_ctrl_t;

	function automatic logic [7:0] get_reg(sm83ls_state_t st, logic [2:0] code);
		logic [7:0] v;
		unique case (code)
			REG_B:   v = st.b;
			REG_C:   v = st.c;
			REG_D:   v = st.d;
			REG_E:   v = st.e;
			REG_H:   v = st.h;
			REG_L:   v = st.l;
			REG_A:   v = st.a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic sm83ls_state_t set_reg(sm83ls_state_t st, logic [2:0] code,
			logic [7:0] v);
		sm83ls_state_t r;
		r = st;
		unique case (code)
			REG_B:   r.b = v;
			REG_C:   r.c = v;
			REG_D:   r.d = v;
			REG_E:   r.e = v;
			REG_H:   r.h = v;
			REG_L:   r.l = v;
			REG_A:   r.a = v;
			default: r = st;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/sm83ls_exec.sv]
// Decode and execute of one load-group transaction against the register file.
// Purely combinational; depends on sm83ls_pkg.
module sm83ls_exec (
	input  logic                      command,
	input  logic [7:0]                opcode,
	input  logic [15:0]               immediate,
	input  logic [7:0]                read_data,
	input  logic                      beat2,
	input  sm83ls_pkg::sm83ls_state_t st,
	output sm83ls_pkg::sm83ls_state_t nst,
	output sm83ls_pkg::sm83ls_result_t res,
	output sm83ls_pkg::sm83ls_ctrl_t  ctrl
);
	import sm83ls_pkg::*;

	logic [15:0] hl;
	logic [15:0] off;
	logic [15:0] sum;
	logic [15:0] chk;
	logic [2:0]  dst;
	logic [2:0]  src;
	logic [7:0]  d8;

	assign hl  = {st.h, st.l};
	assign d8  = immediate[7:0];
	assign dst = opcode[5:3];
	assign src = opcode[2:0];

	// SP plus sign-extended offset, with nibble and byte carries
	assign off = {{8{d8[7]}}, d8};
	assign sum = st.sp + off;
	assign chk = st.sp ^ off ^ sum;

	// Decode the transaction and form the next state and result
	always_comb begin
		nst       = st;
		res       = '0;
		res.last  = 1'b1;
		ctrl.emit = 1'b1;
		ctrl.more = 1'b0;
		if (command == CMD_RETURN) begin
			if (!st.rd_pend) begin
				ctrl.emit = 1'b0;
			end else begin
				nst.rd_pend = 1'b0;
				nst = set_reg(nst, st.rd_tgt, read_data);
				res.cyc = st.pend_cyc;
			end
		end else begin
			nst.rd_pend = 1'b0;
			if (opcode >= OP_MOVE_LO && opcode <= OP_MOVE_HI && opcode != OP_HALT) begin
				if (src == REG_MEM) begin
					nst.rd_pend  = 1'b1;
					nst.rd_tgt   = dst;
					nst.pend_cyc = 3'd2;
					res.kind     = ACC_READ;
					res.addr     = hl;
				end else if (dst == REG_MEM) begin
					res.kind = ACC_WRITE;
					res.addr = hl;
					res.data = get_reg(st, src);
					res.cyc  = 3'd2;
				end else begin
					nst = set_reg(nst, dst, get_reg(st, src));
					res.cyc = 3'd1;
				end
			end else if (opcode < OP_MOVE_LO && (opcode & OP_D8_MASK) == OP_D8_MATCH) begin
				if (dst == REG_MEM) begin
					res.kind = ACC_WRITE;
					res.addr = hl;
					res.data = d8;
					res.cyc  = 3'd3;
				end else begin
					nst = set_reg(nst, dst, d8);
					res.cyc = 3'd2;
				end
			end else begin
				unique case (opcode)
					OP_LD_BC_D16: begin
						{nst.b, nst.c} = immediate;
						res.cyc = 3'd3;
					end
					OP_LD_DE_D16: begin
						{nst.d, nst.e} = immediate;
						res.cyc = 3'd3;
					end
					OP_LD_HL_D16: begin
						{nst.h, nst.l} = immediate;
						res.cyc = 3'd3;
					end
					OP_LD_SP_D16: begin
						nst.sp  = immediate;
						res.cyc = 3'd3;
					end
					OP_ST_BC_A, OP_ST_DE_A, OP_ST_HLI_A, OP_ST_HLD_A,
					OP_LDH_C_A: begin
						res.kind = ACC_WRITE;
						res.data = st.a;
						res.cyc  = 3'd2;
						unique case (opcode)
							OP_ST_BC_A: res.addr = {st.b, st.c};
							OP_ST_DE_A: res.addr = {st.d, st.e};
							OP_LDH_C_A: res.addr = {HIGH_PAGE, st.c};
							default:    res.addr = hl;
						endcase
						if (opcode == OP_ST_HLI_A) {nst.h, nst.l} = hl + 16'd1;
						if (opcode == OP_ST_HLD_A) {nst.h, nst.l} = hl - 16'd1;
					end
					OP_LDH_A8_A: begin
						res.kind = ACC_WRITE;
						res.addr = {HIGH_PAGE, d8};
						res.data = st.a;
						res.cyc  = 3'd3;
					end
					OP_ST_A16_A: begin
						res.kind = ACC_WRITE;
						res.addr = immediate;
						res.data = st.a;
						res.cyc  = 3'd4;
					end
					OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_HLI, OP_LD_A_HLD,
					OP_LDH_A_A8, OP_LDH_A_C, OP_LD_A_A16: begin
						nst.rd_pend = 1'b1;
						nst.rd_tgt  = REG_A;
						res.kind    = ACC_READ;
						unique case (opcode)
							OP_LD_A_BC: begin
								res.addr     = {st.b, st.c};
								nst.pend_cyc = 3'd2;
							end
							OP_LD_A_DE: begin
								res.addr     = {st.d, st.e};
								nst.pend_cyc = 3'd2;
							end
							OP_LDH_A_A8: begin
								res.addr     = {HIGH_PAGE, d8};
								nst.pend_cyc = 3'd3;
							end
							OP_LDH_A_C: begin
								res.addr     = {HIGH_PAGE, st.c};
								nst.pend_cyc = 3'd2;
							end
							OP_LD_A_A16: begin
								res.addr     = immediate;
								nst.pend_cyc = 3'd4;
							end
							default: begin
								res.addr     = hl;
								nst.pend_cyc = 3'd2;
							end
						endcase
						if (opcode == OP_LD_A_HLI) {nst.h, nst.l} = hl + 16'd1;
						if (opcode == OP_LD_A_HLD) {nst.h, nst.l} = hl - 16'd1;
					end
					OP_ST_A16_SP: begin
						// Low byte first, then high byte on the second beat
						res.kind = ACC_WRITE;
						if (!beat2) begin
							res.addr  = immediate;
							res.data  = st.sp[7:0];
							res.last  = 1'b0;
							ctrl.more = 1'b1;
						end else begin
							res.addr = immediate + 16'd1;
							res.data = st.sp[15:8];
							res.cyc  = 3'd5;
						end
					end
					OP_LD_SP_HL: begin
						nst.sp  = hl;
						res.cyc = 3'd2;
					end
					OP_LD_HL_SPR: begin
						{nst.h, nst.l} = sum;
						nst.flags = {2'b00, chk[4], chk[8]};
						res.cyc = 3'd3;
					end
					default: begin
						res.unsup = 1'b1;
						nst.rd_pend = 1'b0;
					end
				endcase
			end
		end
	end

endmodule

[rtl/core/sm83_load_store_unit.sv]
// SM83 load/store unit: input register, one execute pass, output register.
// A transaction is registered in the input stage, executed, and its result registered in the output stage.
// Throughput: one transaction per clock unless the output stalls; LD (a16),SP holds execute for a second beat.
// A data return with no read outstanding gives no result.
// arst_n clears the register file, flags, pending read and both valid stages.
// Depends on sm83ls_pkg and sm83ls_exec.
module sm83_load_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  opcode,
	input  logic [15:0] immediate,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  access_kind,
	output logic [15:0] bus_address,
	output logic [7:0]  bus_data,
	output logic [2:0]  machine_cycles,
	output logic        last,
	output logic        unsupported,
	output logic [7:0]  reg_a,
	output logic [15:0] reg_bc,
	output logic [15:0] reg_de,
	output logic [15:0] reg_hl,
	output logic [15:0] reg_sp,
	output logic [3:0]  flags_znhc
);
	import sm83ls_pkg::*;

	logic           valid_s1;
	logic           command_s1;
	logic [7:0]     opcode_s1;
	logic [15:0]    immediate_s1;
	logic [7:0]     read_data_s1;
	logic           beat2_q;
	sm83ls_state_t  state_q;
	sm83ls_state_t  state_nxt;
	sm83ls_result_t res;
	sm83ls_ctrl_t   ctrl;
	logic           out_free;
	logic           exec_go;
	logic           consume;

	sm83ls_exec u_exec (
		.command   (command_s1),
		.opcode    (opcode_s1),
		.immediate (immediate_s1),
		.read_data (read_data_s1),
		.beat2     (beat2_q),
		.st        (state_q),
		.nst       (state_nxt),
		.res       (res),
		.ctrl      (ctrl)
	);

	// Execute when the output stage can take the result, or none is produced
	assign out_free = !out_valid || out_ready;
	assign exec_go  = valid_s1 && (!ctrl.emit || out_free);
	assign consume  = exec_go && !ctrl.more;
	assign in_ready = !valid_s1 || consume;

	// Advance the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1   <= command;
			opcode_s1    <= opcode;
			immediate_s1 <= immediate;
			read_data_s1 <= read_data;
		end
	end

	// Update architectural state and the second-beat marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			beat2_q <= 1'b0;
		end else if (exec_go) begin
			state_q <= state_nxt;
			beat2_q <= ctrl.more;
		end
	end

	// Hold or load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (exec_go && ctrl.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && ctrl.emit) begin
			access_kind    <= res.kind;
			bus_address    <= res.addr;
			bus_data       <= res.data;
			machine_cycles <= res.cyc;
			last           <= res.last;
			unsupported    <= res.unsup;
			reg_a          <= state_nxt.a;
			reg_bc         <= {state_nxt.b, state_nxt.c};
			reg_de         <= {state_nxt.d, state_nxt.e};
			reg_hl         <= {state_nxt.h, state_nxt.l};
			reg_sp         <= state_nxt.sp;
			flags_znhc     <= state_nxt.flags;
		end
	end

`ifndef SYNTHESIS
	a_beat2_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		beat2_q |-> valid_s1 && command_s1 == CMD_EXEC && opcode_s1 == OP_ST_A16_SP)
		else $error("second beat without an SP store in execute");

	a_pending_has_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rd_pend |-> state_q.pend_cyc != 3'd0)
		else $error("read outstanding with zero cycle count");

	a_nonlast_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> access_kind == ACC_WRITE && machine_cycles == 3'd0)
		else $error("non-final result is not a plain write");

	a_unsup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> access_kind == ACC_NONE && machine_cycles == 3'd0)
		else $error("unsupported result carries an access or cycles");

	a_read_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && ctrl.emit && res.kind == ACC_READ |=> state_q.rd_pend)
		else $error("read request issued without marking a pending read");
`endif

endmodule

[test/sm83ls_load_checker.sv]
// Checker for the SM83 load/store unit: predicts the bus results of each accepted
// transaction and compares them with the results the unit hands out.
// Depends on sm83ls_pkg for command, access-kind, register and opcode codes.
module sm83ls_load_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [7:0]  opcode,
	input  logic [15:0] immediate,
	input  logic [7:0]  read_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  access_kind,
	input  logic [15:0] bus_address,
	input  logic [7:0]  bus_data,
	input  logic [2:0]  machine_cycles,
	input  logic        last,
	input  logic        unsupported,
	input  logic [7:0]  reg_a,
	input  logic [15:0] reg_bc,
	input  logic [15:0] reg_de,
	input  logic [15:0] reg_hl,
	input  logic [15:0] reg_sp,
	input  logic [3:0]  flags_znhc,
	output int          fail_count,
	output int          results_due
);
	import sm83ls_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [2:0]  cyc;
		logic        is_last;
		logic        unsup;
		logic [7:0]  a;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] sp;
		logic [3:0]  flags;
	} bus_result_t;

	// Shadow register file of the unit
	logic [7:0]  a_q = '0, b_q = '0, c_q = '0, d_q = '0, e_q = '0, h_q = '0, l_q = '0;
	logic [15:0] sp_q = '0;
	logic [3:0]  flags_q = '0;
	logic        rd_wait = 1'b0;
	logic [2:0]  rd_dest = '0;
	logic [2:0]  rd_cycles = '0;

	bus_result_t due_results[$];
	bus_result_t want;
	int          mismatches = 0;
	int          due_count = 0;

	assign fail_count  = mismatches;
	assign results_due = due_count;

	function logic [7:0] reg_byte(input logic [2:0] code);
		case (code)
			REG_B:   return b_q;
			REG_C:   return c_q;
			REG_D:   return d_q;
			REG_E:   return e_q;
			REG_H:   return h_q;
			REG_L:   return l_q;
			REG_A:   return a_q;
			default: return 8'h00;
		endcase
	endfunction

	task put_byte(input logic [2:0] code, input logic [7:0] v);
		case (code)
			REG_B:   b_q = v;
			REG_C:   c_q = v;
			REG_D:   d_q = v;
			REG_E:   e_q = v;
			REG_H:   h_q = v;
			REG_L:   l_q = v;
			REG_A:   a_q = v;
			default: ;
		endcase
	endtask

	// Queue one result with a snapshot of the shadow registers
	task push_result(input logic [1:0] kind, input logic [15:0] addr, input logic [7:0] data,
			input logic [2:0] cyc, input logic is_last, input logic unsup);
		bus_result_t r;
		r = '{kind, addr, data, cyc, is_last, unsup, a_q, {b_q, c_q}, {d_q, e_q},
			{h_q, l_q}, sp_q, flags_q};
		due_results.push_back(r);
	endtask

	task issue_read(input logic [15:0] addr, input logic [2:0] dest, input logic [2:0] cyc);
		rd_wait   = 1'b1;
		rd_dest   = dest;
		rd_cycles = cyc;
		push_result(ACC_READ, addr, 8'h00, 3'd0, 1'b1, 1'b0);
	endtask

	// Run one transaction of the load group on the shadow state
	task run_load_group(input logic cmd, input logic [7:0] op, input logic [15:0] imm,
			input logic [7:0] rdata);
		logic [15:0] hl, off, sum, chk;
		logic [7:0]  d8;
		logic [2:0]  dst, src;
		hl  = {h_q, l_q};
		d8  = imm[7:0];
		dst = op[5:3];
		src = op[2:0];
		if (cmd == CMD_RETURN) begin
			// a data return with no read outstanding is dropped
			if (rd_wait) begin
				rd_wait = 1'b0;
				put_byte(rd_dest, rdata);
				push_result(ACC_NONE, 16'h0000, 8'h00, rd_cycles, 1'b1, 1'b0);
			end
		end else begin
			// any execute abandons an outstanding read
			rd_wait = 1'b0;
			if (op >= OP_MOVE_LO && op <= OP_MOVE_HI && op != OP_HALT) begin
				if (src == REG_MEM)
					issue_read(hl, dst, 3'd2);
				else if (dst == REG_MEM)
					push_result(ACC_WRITE, hl, reg_byte(src), 3'd2, 1'b1, 1'b0);
				else begin
					put_byte(dst, reg_byte(src));
					push_result(ACC_NONE, 16'h0000, 8'h00, 3'd1, 1'b1, 1'b0);
				end
			end else if (op < OP_MOVE_LO && (op & OP_D8_MASK) == OP_D8_MATCH) begin
				if (dst == REG_MEM)
					push_result(ACC_WRITE, hl, d8, 3'd3, 1'b1, 1'b0);
				else begin
					put_byte(dst, d8);
					push_result(ACC_NONE, 16'h0000, 8'h00, 3'd2, 1'b1, 1'b0);
				end
			end else begin
				case (op)
					OP_LD_BC_D16: begin
						{b_q, c_q} = imm;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd3, 1'b1, 1'b0);
					end
					OP_LD_DE_D16: begin
						{d_q, e_q} = imm;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd3, 1'b1, 1'b0);
					end
					OP_LD_HL_D16: begin
						{h_q, l_q} = imm;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd3, 1'b1, 1'b0);
					end
					OP_LD_SP_D16: begin
						sp_q = imm;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd3, 1'b1, 1'b0);
					end
					OP_ST_BC_A: push_result(ACC_WRITE, {b_q, c_q}, a_q, 3'd2, 1'b1, 1'b0);
					OP_ST_DE_A: push_result(ACC_WRITE, {d_q, e_q}, a_q, 3'd2, 1'b1, 1'b0);
					// post increment and decrement: bus sees old HL, snapshot the new one
					OP_ST_HLI_A: begin
						{h_q, l_q} = hl + 16'd1;
						push_result(ACC_WRITE, hl, a_q, 3'd2, 1'b1, 1'b0);
					end
					OP_ST_HLD_A: begin
						{h_q, l_q} = hl - 16'd1;
						push_result(ACC_WRITE, hl, a_q, 3'd2, 1'b1, 1'b0);
					end
					OP_LD_A_BC: issue_read({b_q, c_q}, REG_A, 3'd2);
					OP_LD_A_DE: issue_read({d_q, e_q}, REG_A, 3'd2);
					OP_LD_A_HLI: begin
						{h_q, l_q} = hl + 16'd1;
						issue_read(hl, REG_A, 3'd2);
					end
					OP_LD_A_HLD: begin
						{h_q, l_q} = hl - 16'd1;
						issue_read(hl, REG_A, 3'd2);
					end
					OP_LDH_A8_A: push_result(ACC_WRITE, {HIGH_PAGE, d8}, a_q, 3'd3, 1'b1, 1'b0);
					OP_LDH_C_A:  push_result(ACC_WRITE, {HIGH_PAGE, c_q}, a_q, 3'd2, 1'b1, 1'b0);
					OP_ST_A16_A: push_result(ACC_WRITE, imm, a_q, 3'd4, 1'b1, 1'b0);
					OP_LDH_A_A8: issue_read({HIGH_PAGE, d8}, REG_A, 3'd3);
					OP_LDH_A_C:  issue_read({HIGH_PAGE, c_q}, REG_A, 3'd2);
					OP_LD_A_A16: issue_read(imm, REG_A, 3'd4);
					// SP goes out low byte first, the second address wraps
					OP_ST_A16_SP: begin
						push_result(ACC_WRITE, imm, sp_q[7:0], 3'd0, 1'b0, 1'b0);
						push_result(ACC_WRITE, imm + 16'd1, sp_q[15:8], 3'd5, 1'b1, 1'b0);
					end
					OP_LD_SP_HL: begin
						sp_q = hl;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd2, 1'b1, 1'b0);
					end
					// signed offset; H and C from the carries out of bits 3 and 7
					OP_LD_HL_SPR: begin
						off     = {{8{d8[7]}}, d8};
						sum     = sp_q + off;
						chk     = sp_q ^ off ^ sum;
						flags_q = {2'b00, chk[4], chk[8]};
						{h_q, l_q} = sum;
						push_result(ACC_NONE, 16'h0000, 8'h00, 3'd3, 1'b1, 1'b0);
					end
					default: push_result(ACC_NONE, 16'h0000, 8'h00, 3'd0, 1'b1, 1'b1);
				endcase
			end
		end
	endtask

	task compare_field(input string field, input logic [15:0] want_v, input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", field, want_v, got_v);
			mismatches++;
		end
	endtask

	// Predict on every input transaction, compare on every result transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{a_q, b_q, c_q, d_q, e_q, h_q, l_q} = '0;
			sp_q      = '0;
			flags_q   = '0;
			rd_wait   = 1'b0;
			rd_dest   = '0;
			rd_cycles = '0;
			due_results.delete();
			due_count <= 0;
		end else begin
			if (in_valid && in_ready)
				run_load_group(command, opcode, immediate, read_data);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					compare_field("access_kind", 16'(want.kind), 16'(access_kind));
					compare_field("bus_address", want.addr, bus_address);
					compare_field("bus_data", 16'(want.data), 16'(bus_data));
					compare_field("machine_cycles", 16'(want.cyc), 16'(machine_cycles));
					compare_field("last", 16'(want.is_last), 16'(last));
					compare_field("unsupported", 16'(want.unsup), 16'(unsupported));
					compare_field("reg_a", 16'(want.a), 16'(reg_a));
					compare_field("reg_bc", want.bc, reg_bc);
					compare_field("reg_de", want.de, reg_de);
					compare_field("reg_hl", want.hl, reg_hl);
					compare_field("reg_sp", want.sp, reg_sp);
					compare_field("flags_znhc", 16'(want.flags), 16'(flags_znhc));
				end
			end
			due_count <= due_results.size();
		end
	end

endmodule

[test/sm83_load_store_unit_tb.sv]
// Testbench top for the SM83 load/store unit: clock, reset, load-group stimulus
// with random idling on both channels, and the verdict.
// Depends on sm83ls_pkg, sm83_load_store_unit and sm83ls_load_checker.
module sm83_load_store_unit_tb;
	import sm83ls_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RANDOM_ITEMS = 500;
	localparam logic [7:0] OP_NOP = 8'h00;
	localparam logic [7:0] GROUP_OPS [22] = '{OP_LD_BC_D16, OP_LD_DE_D16, OP_LD_HL_D16,
		OP_LD_SP_D16, OP_ST_BC_A, OP_ST_DE_A, OP_ST_HLI_A, OP_ST_HLD_A, OP_LD_A_BC,
		OP_LD_A_DE, OP_LD_A_HLI, OP_LD_A_HLD, OP_LDH_A8_A, OP_LDH_C_A, OP_ST_A16_A,
		OP_LDH_A_A8, OP_LDH_A_C, OP_LD_A_A16, OP_ST_A16_SP, OP_LD_SP_HL, OP_LD_HL_SPR,
		OP_HALT};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_EXEC;
	logic [7:0]  opcode = OP_NOP;
	logic [15:0] immediate = '0;
	logic [7:0]  read_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  access_kind;
	logic [15:0] bus_address;
	logic [7:0]  bus_data;
	logic [2:0]  machine_cycles;
	logic        last;
	logic        unsupported;
	logic [7:0]  reg_a;
	logic [15:0] reg_bc;
	logic [15:0] reg_de;
	logic [15:0] reg_hl;
	logic [15:0] reg_sp;
	logic [3:0]  flags_znhc;
	int          fail_count;
	int          results_due;
	logic        calm = 1'b0;

	sm83_load_store_unit u_dut (.*);

	sm83ls_load_checker u_check (.*);

	always #2 clk = ~clk;

	// Drive one input transaction and hold it until accepted
	task automatic send_item(input logic cmd, input logic [7:0] op, input logic [15:0] imm,
			input logic [7:0] rd);
		in_valid  <= 1'b1;
		command   <= cmd;
		opcode    <= op;
		immediate <= imm;
		read_data <= rd;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_exec(input logic [7:0] op, input logic [15:0] imm);
		send_item(CMD_EXEC, op, imm, 8'($urandom));
	endtask

	task automatic send_return(input logic [7:0] rd);
		send_item(CMD_RETURN, 8'($urandom), 16'($urandom), rd);
	endtask

	// Drop valid for a random burst now and then
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Hold off the sender until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	// Receiver: ready runs broken by random stall bursts
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL sm83_load_store_unit");
		$finish;
	end

	initial begin
		int          sent;
		int          roll;
		logic        read_open;
		logic        paused;
		logic [7:0]  op;

		sent      = 0;
		read_open = 1'b0;
		paused    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, wrap of HL and of the SP store, abandoned reads
		send_exec(OP_LD_BC_D16, 16'hFFFF);
		send_exec(OP_LD_DE_D16, 16'h8001);
		send_exec(OP_LD_HL_D16, 16'h0000);
		send_exec(OP_LD_SP_D16, 16'hFFFF);
		send_exec({2'b00, REG_A, REG_MEM}, 16'h00FF);
		sender_gap();
		send_exec(OP_ST_HLD_A, 16'h0000);
		send_exec(OP_ST_HLI_A, 16'hFFFF);
		send_exec(OP_LD_A_HLI, 16'h0000);
		send_return(8'hA5);
		send_return(8'hFF);
		send_exec(OP_LD_A_BC, 16'h0000);
		send_exec(OP_ST_A16_SP, 16'hFFFF);
		send_return(8'h00);
		send_exec(OP_LD_HL_SPR, 16'h0080);
		send_exec(OP_LD_HL_SPR, 16'hFF7F);
		send_exec(OP_LD_SP_HL, 16'h0000);
		sender_gap();
		send_exec(OP_LDH_A8_A, 16'h00FF);
		send_exec(OP_LDH_A_C, 16'h0000);
		send_return(8'h3C);
		send_exec(OP_LD_A_A16, 16'hFFFF);
		send_return(8'hC3);
		send_exec({2'b01, REG_MEM, REG_E}, 16'h0000);
		send_exec({2'b01, REG_B, REG_MEM}, 16'h0000);
		send_return(8'h81);
		send_exec(OP_NOP, 16'h0000);
		send_exec(OP_HALT, 16'h0000);
		drain();

		// Random: mostly load sequences with their data returns, some stray returns
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - 80)
				calm = 1'b1;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
			sender_gap();
			roll = $urandom_range(0, 99);
			if (read_open && roll < 85) begin
				send_return(8'($urandom));
				sent++;
				read_open = 1'b0;
			end else if (roll < 8) begin
				// stray return: completes an open read, otherwise ignored
				send_return(8'($urandom));
				if (read_open)
					sent++;
				read_open = 1'b0;
			end else begin
				if ($urandom_range(0, 1) == 0)
					op = 8'($urandom);
				else
					op = GROUP_OPS[$urandom_range(0, 21)];
				send_exec(op, 16'($urandom));
				sent++;
				read_open = (op >= OP_MOVE_LO && op <= OP_MOVE_HI && op != OP_HALT
					&& op[2:0] == REG_MEM) || op == OP_LD_A_BC || op == OP_LD_A_DE
					|| op == OP_LD_A_HLI || op == OP_LD_A_HLD || op == OP_LDH_A_A8
					|| op == OP_LDH_A_C || op == OP_LD_A_A16;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS sm83_load_store_unit");
		else
			$display("FAIL sm83_load_store_unit");
		$finish;
	end

endmodule
